// ----- sv/hrt_pkg.sv -----
// hrt_pkg: sizes, operation codes and scan interface types of the history ring store
// used by the top level, the walker and the checker; depends on nothing
package hrt_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int QUEUE_DEPTH   = 8;

  localparam int HA  = $clog2(HISTORY_DEPTH);
  localparam int HFW = $clog2(HISTORY_DEPTH + 1);
  localparam int QA  = $clog2(QUEUE_DEPTH);
  localparam int QPW = $clog2(2 * QUEUE_DEPTH);

  localparam int UID_W = 32;
  localparam int REC_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int OP_W  = 4;

  localparam int IN_FIELDS_W  = UID_W + REC_W + IDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = UID_W + REC_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 4'd0,
    OP_RM_PHONE  = 4'd1,
    OP_RM_USER   = 4'd2,
    OP_READ_AT   = 4'd3,
    OP_COUNT     = 4'd4,
    OP_POP_PEND  = 4'd5,
    OP_POP_GONE  = 4'd6,
    OP_RESET_Q   = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    SCAN_REMOVE = 2'd0,
    SCAN_READ   = 2'd1,
    SCAN_COUNT  = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic             start;
    scan_mode_t       mode;
    logic [HFW-1:0]   fill;
    logic [HA-1:0]    wp;
    logic [IDX_W-1:0] idx;
    logic [UID_W-1:0] uid;
  } scan_req_t;

  typedef struct packed {
    logic           done;
    logic           hit;
    logic [HA-1:0]  slot;
    logic [HFW-1:0] count;
  } scan_res_t;

  function automatic logic [QA-1:0] q_slot(input logic [QPW-1:0] p);
    logic [QA-1:0] s;
    if (p >= QPW'(QUEUE_DEPTH)) begin
      s = QA'(p - QPW'(QUEUE_DEPTH));
    end else begin
      s = QA'(p);
    end
    return s;
  endfunction

  function automatic logic [QPW-1:0] q_next(input logic [QPW-1:0] p);
    logic [QPW-1:0] n;
    if (p == QPW'(2 * QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QPW'(1);
    end
    return n;
  endfunction

  function automatic logic q_full(input logic [QPW-1:0] wr, input logic [QPW-1:0] rd);
    logic [QPW:0] occ;
    if (wr >= rd) begin
      occ = (QPW+1)'(wr) - (QPW+1)'(rd);
    end else begin
      occ = (QPW+1)'(2 * QUEUE_DEPTH) - ((QPW+1)'(rd) - (QPW+1)'(wr));
    end
    return occ >= (QPW+1)'(QUEUE_DEPTH);
  endfunction

endpackage

// ----- sv/history_ring_with_tombstones_unit.sv -----
// history_ring_with_tombstones_unit: top level of the history ring store with
// pending and removed-uid queues; depends on hrt_pkg, hrt_ram and hrt_walker
//
// use: one item on the in_ channel carries an operation (in_tuser) and its uid,
// record handle and slot index (in_tdata); each item gives exactly one result item
// on the out_ channel with ok (out_tuser) and uid, record handle and live count.
// the block works on one item at a time: in_tready is high only while idle.
// push, queue reset, clear and unknown codes go from the exec state to the done state;
// a pop that finds an entry passes through a fetch state first. removal, indexed read
// and count walk the history newest first through one slot walker that reads one
// history ram entry per cycle, up to a full ring of 16; a read hit then goes to fetch.
// a result waits in the output register while out_tready is low; the next item is
// accepted meanwhile and its result is held back until the register frees.
// reset (rst_n low, synchronous) empties the history and both queues and drops
// any result in flight; no clearing pass follows, the block is ready next cycle.
module history_ring_with_tombstones_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hrt_pkg::IN_TDATA_W-1:0]     in_tdata,  // uid, record_handle, slot_index, zero pad
  input  logic [hrt_pkg::OP_W-1:0]           in_tuser,  // operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hrt_pkg::OUT_TDATA_W-1:0]    out_tdata, // uid_out, record_out, live_count, zero pad
  output logic [0:0]                         out_tuser  // ok
);
  import hrt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  op_t              op_r;
  logic [UID_W-1:0] uid_r;
  logic [REC_W-1:0] rec_r;
  logic [IDX_W-1:0] idx_r;

  logic [HA-1:0]            wp_r, wp_nxt;
  logic [HFW-1:0]           fill_r, fill_nxt;
  logic [HISTORY_DEPTH-1:0] live_r, live_nxt;
  logic [QPW-1:0]           pend_wr_r, pend_wr_nxt, pend_rd_r, pend_rd_nxt;
  logic [QPW-1:0]           gone_wr_r, gone_wr_nxt, gone_rd_r, gone_rd_nxt;

  logic             res_ok_r, res_ok_nxt;
  logic [UID_W-1:0] res_uid_r, res_uid_nxt;
  logic [REC_W-1:0] res_rec_r, res_rec_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_ok_r;
  logic                   out_load;

  logic hist_we, pend_we, gone_we;
  logic [2*UID_W-1:0] hist_rdata, pend_rdata;
  logic [UID_W-1:0]   gone_rdata;

  scan_req_t     scan_req;
  scan_res_t     scan_res;
  logic [HA-1:0] walk_slot, walk_stage_slot;

  logic accept;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  hrt_ram #(.WIDTH(UID_W + REC_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp_r),
    .wdata ({rec_r, uid_r}),
    .raddr (walk_slot),
    .rdata (hist_rdata)
  );

  hrt_ram #(.WIDTH(UID_W + REC_W), .DEPTH(QUEUE_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (q_slot(pend_wr_r)),
    .wdata ({rec_r, uid_r}),
    .raddr (q_slot(pend_rd_r)),
    .rdata (pend_rdata)
  );

  hrt_ram #(.WIDTH(UID_W), .DEPTH(QUEUE_DEPTH)) u_gone_ram (
    .clk   (clk),
    .we    (gone_we),
    .waddr (q_slot(gone_wr_r)),
    .wdata (uid_r),
    .raddr (q_slot(gone_rd_r)),
    .rdata (gone_rdata)
  );

  hrt_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (scan_req),
    .live_at_slot  (live_r[walk_slot]),
    .live_at_stage (live_r[walk_stage_slot]),
    .ram_uid       (hist_rdata[UID_W-1:0]),
    .slot          (walk_slot),
    .stage_slot    (walk_stage_slot),
    .res           (scan_res)
  );

  always_comb begin
    scan_req.fill = fill_r;
    scan_req.wp   = wp_r;
    scan_req.idx  = idx_r;
    scan_req.uid  = uid_r;
    scan_req.start = 1'b0;
    scan_req.mode  = SCAN_REMOVE;
    if (state_r == ST_EXEC) begin
      case (op_r) inside
        OP_RM_PHONE, OP_RM_USER: begin
          scan_req.start = 1'b1;
        end
        OP_READ_AT: begin
          scan_req.start = 1'b1;
          scan_req.mode  = SCAN_READ;
        end
        OP_COUNT: begin
          scan_req.start = 1'b1;
          scan_req.mode  = SCAN_COUNT;
        end
        default: begin
          scan_req.start = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    live_nxt    = live_r;
    pend_wr_nxt = pend_wr_r;
    pend_rd_nxt = pend_rd_r;
    gone_wr_nxt = gone_wr_r;
    gone_rd_nxt = gone_rd_r;
    res_ok_nxt  = res_ok_r;
    res_uid_nxt = res_uid_r;
    res_rec_nxt = res_rec_r;
    res_cnt_nxt = res_cnt_r;
    hist_we     = 1'b0;
    pend_we     = 1'b0;
    gone_we     = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_ok_nxt  = 1'b0;
        res_uid_nxt = '0;
        res_rec_nxt = '0;
        res_cnt_nxt = '0;
        state_nxt   = ST_DONE;
        unique case (op_r) inside
          OP_PUSH: begin
            hist_we        = 1'b1;
            live_nxt[wp_r] = 1'b1;
            if (wp_r == HA'(HISTORY_DEPTH - 1)) begin
              wp_nxt = '0;
            end else begin
              wp_nxt = wp_r + HA'(1);
            end
            if (fill_r < HFW'(HISTORY_DEPTH)) begin
              fill_nxt = fill_r + HFW'(1);
            end
            if (q_full(pend_wr_r, pend_rd_r)) begin
              pend_rd_nxt = q_next(pend_rd_r);
            end
            pend_we     = 1'b1;
            pend_wr_nxt = q_next(pend_wr_r);
            res_ok_nxt  = 1'b1;
          end
          OP_RM_PHONE: begin
            if (q_full(gone_wr_r, gone_rd_r)) begin
              gone_rd_nxt = q_next(gone_rd_r);
            end
            gone_we     = 1'b1;
            gone_wr_nxt = q_next(gone_wr_r);
            state_nxt   = ST_SCAN;
          end
          OP_RM_USER, OP_READ_AT, OP_COUNT: begin
            state_nxt = ST_SCAN;
          end
          OP_POP_PEND: begin
            if (pend_rd_r != pend_wr_r) begin
              pend_rd_nxt = q_next(pend_rd_r);
              state_nxt   = ST_FETCH;
            end
          end
          OP_POP_GONE: begin
            if (gone_rd_r != gone_wr_r) begin
              gone_rd_nxt = q_next(gone_rd_r);
              state_nxt   = ST_FETCH;
            end
          end
          OP_RESET_Q: begin
            pend_rd_nxt = pend_wr_r;
            gone_rd_nxt = gone_wr_r;
            res_ok_nxt  = 1'b1;
          end
          OP_CLEAR: begin
            live_nxt    = '0;
            fill_nxt    = '0;
            wp_nxt      = '0;
            pend_rd_nxt = pend_wr_r;
            gone_rd_nxt = gone_wr_r;
            res_ok_nxt  = 1'b1;
          end
          default: begin
            res_ok_nxt = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_DONE;
          case (op_r)
            OP_READ_AT: begin
              if (scan_res.hit) begin
                state_nxt = ST_FETCH;
              end
            end
            OP_COUNT: begin
              res_ok_nxt  = 1'b1;
              res_cnt_nxt = CNT_W'(scan_res.count);
            end
            default: begin
              res_ok_nxt = scan_res.hit;
              if (scan_res.hit) begin
                live_nxt[scan_res.slot] = 1'b0;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_nxt  = ST_DONE;
        res_ok_nxt = 1'b1;
        case (op_r)
          OP_READ_AT: begin
            res_uid_nxt = hist_rdata[UID_W-1:0];
            res_rec_nxt = hist_rdata[UID_W +: REC_W];
          end
          OP_POP_PEND: begin
            res_uid_nxt = pend_rdata[UID_W-1:0];
            res_rec_nxt = pend_rdata[UID_W +: REC_W];
          end
          default: begin
            res_uid_nxt = gone_rdata;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      live_r      <= '0;
      pend_wr_r   <= '0;
      pend_rd_r   <= '0;
      gone_wr_r   <= '0;
      gone_rd_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      live_r      <= live_nxt;
      pend_wr_r   <= pend_wr_nxt;
      pend_rd_r   <= pend_rd_nxt;
      gone_wr_r   <= gone_wr_nxt;
      gone_rd_r   <= gone_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_tuser);
      uid_r <= in_tdata[UID_W-1:0];
      rec_r <= in_tdata[UID_W +: REC_W];
      idx_r <= in_tdata[UID_W + REC_W +: IDX_W];
    end
    res_ok_r  <= res_ok_nxt;
    res_uid_r <= res_uid_nxt;
    res_rec_r <= res_rec_nxt;
    res_cnt_r <= res_cnt_nxt;
    if (out_load) begin
      out_ok_r   <= res_ok_r;
      out_data_r <= OUT_TDATA_W'({res_cnt_r, res_rec_r, res_uid_r});
    end
  end

endmodule

// ----- sv/hrt_ram.sv -----
// hrt_ram: generic single write port, single read port ram with registered read
// no dependencies
module hrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/hrt_walker.sv -----
// hrt_walker: walks history slots newest first, one slot per cycle, for removal,
// indexed read and count; depends on hrt_pkg
module hrt_walker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hrt_pkg::scan_req_t             req,
  input  logic                           live_at_slot,
  input  logic                           live_at_stage,
  input  logic [hrt_pkg::UID_W-1:0]      ram_uid,
  output logic [hrt_pkg::HA-1:0]         slot,
  output logic [hrt_pkg::HA-1:0]         stage_slot,
  output hrt_pkg::scan_res_t             res
);
  import hrt_pkg::*;

  logic             busy_r, busy_nxt;
  scan_mode_t       mode_r;
  logic [HFW-1:0]   fill_r;
  logic [IDX_W-1:0] idx_r;
  logic [UID_W-1:0] uid_r;
  logic [HFW-1:0]   step_r, step_nxt;
  logic [HA-1:0]    slot_r, slot_nxt;
  logic [HFW-1:0]   tally_r, tally_nxt;
  logic             stg_v_r, stg_v_nxt;
  logic [HA-1:0]    stg_slot_r;

  logic issue;
  logic match;
  logic read_hit;
  logic done;

  assign issue    = busy_r && (step_r < fill_r);
  assign match    = stg_v_r && live_at_stage && (ram_uid == uid_r);
  assign read_hit = (mode_r == SCAN_READ) && issue && live_at_slot &&
                    (32'(tally_r) == 32'(idx_r));
  assign done     = busy_r && (match || read_hit || (!issue && !stg_v_r));

  assign slot       = slot_r;
  assign stage_slot = stg_slot_r;
  assign res.done   = done;
  assign res.hit    = match || read_hit;
  assign res.slot   = match ? stg_slot_r : slot_r;
  assign res.count  = tally_r;

  always_comb begin
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    slot_nxt  = slot_r;
    tally_nxt = tally_r;
    stg_v_nxt = stg_v_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      step_nxt  = '0;
      tally_nxt = '0;
      stg_v_nxt = 1'b0;
      if (req.wp == '0) begin
        slot_nxt = HA'(HISTORY_DEPTH - 1);
      end else begin
        slot_nxt = req.wp - HA'(1);
      end
    end else if (busy_r) begin
      if (done) begin
        busy_nxt  = 1'b0;
        stg_v_nxt = 1'b0;
      end else if (issue) begin
        step_nxt = step_r + HFW'(1);
        if (slot_r == '0) begin
          slot_nxt = HA'(HISTORY_DEPTH - 1);
        end else begin
          slot_nxt = slot_r - HA'(1);
        end
        if (mode_r != SCAN_REMOVE) begin
          tally_nxt = tally_r + HFW'(live_at_slot);
        end
        stg_v_nxt = (mode_r == SCAN_REMOVE) && live_at_slot;
      end else begin
        stg_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      stg_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    slot_r     <= slot_nxt;
    tally_r    <= tally_nxt;
    stg_slot_r <= slot_r;
    if (req.start) begin
      mode_r <= req.mode;
      fill_r <= req.fill;
      idx_r  <= req.idx;
      uid_r  <= req.uid;
    end
  end

endmodule

// ----- sv/hrt_checker.sv -----
// hrt_checker: port-level checks on the history ring store over time, bound to the
// top level; depends on hrt_pkg and history_ring_with_tombstones_unit
module hrt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [hrt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input logic [hrt_pkg::OP_W-1:0]           in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [hrt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic [0:0]                         out_tuser
);
  import hrt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("failed result carries nonzero fields");

  a_count_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[UID_W + REC_W +: CNT_W] != '0) |-> out_tuser[0])
    else $error("live count reported without ok");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind history_ring_with_tombstones_unit hrt_checker u_hrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
